### rtl/max_tracking_fifo_assert.svh
// Assertion macros for the queue RTL.
`ifndef MAX_TRACKING_FIFO_ASSERT_SVH
`define MAX_TRACKING_FIFO_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MTF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max_tracking_fifo: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max_tracking_fifo: next-cycle check failed");

`endif

### rtl/mtf_pkg.sv
package mtf_pkg;

  // Operation codes on the request channel
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Result error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

  // Per-cell control, built by the top level each cycle
  typedef struct packed {
    logic push_en;   // accepted push that the queue takes
    logic pop_en;    // accepted pop on a non-empty queue
    logic occupied;  // cell holds a live entry
    logic is_tail;   // cell is the first free slot
  } cell_ctrl_t;

endpackage

### rtl/mtf_req_if.sv
interface mtf_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [DATA_WIDTH-1:0] data_value;

  modport source (output valid, output kind, output data_value, input ready);
  modport sink   (input valid, input kind, input data_value, output ready);
endinterface

### rtl/mtf_res_if.sv
interface mtf_res_if #(
  parameter int DATA_WIDTH  = 32,
  parameter int COUNT_WIDTH = 5
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] front_value;
  logic signed [DATA_WIDTH-1:0] queue_maximum;
  logic [COUNT_WIDTH-1:0]       entry_count;
  logic                         is_empty;
  logic [1:0]                   error_code;

  modport source (output valid, output front_value, output queue_maximum,
                  output entry_count, output is_empty, output error_code,
                  input ready);
  modport sink   (input valid, input front_value, input queue_maximum,
                  input entry_count, input is_empty, input error_code,
                  output ready);
endinterface

### rtl/mtf_cell.sv
module mtf_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  mtf_pkg::cell_ctrl_t          ctrl,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  input  logic signed [DATA_WIDTH-1:0] shift_value,
  input  logic signed [DATA_WIDTH-1:0] shift_maximum,
  output logic signed [DATA_WIDTH-1:0] value,
  output logic signed [DATA_WIDTH-1:0] maximum,
  output logic signed [DATA_WIDTH-1:0] value_next,
  output logic signed [DATA_WIDTH-1:0] maximum_next
);

  // Next entry: load on tail push, raise on live push, take neighbor on pop
  always_comb begin
    value_next   = value;
    maximum_next = maximum;
    if (ctrl.push_en) begin
      if (ctrl.is_tail) begin
        value_next   = push_value;
        maximum_next = push_value;
      end else if (ctrl.occupied && (push_value > maximum)) begin
        maximum_next = push_value;
      end
    end else if (ctrl.pop_en) begin
      value_next   = shift_value;
      maximum_next = shift_maximum;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    value   <= value_next;
    maximum <= maximum_next;
  end

endmodule

### rtl/max_tracking_fifo.sv
// Max-tracking FIFO: a queue of signed values that also reports its maximum.
// request channel: kind (push, pop, read; code 3 acts as read) and data_value.
// result channel: one result per request, describing the queue after it:
//   oldest value, queue maximum (both zero when empty), entry count,
//   empty flag and error code (pop on empty, push on full; queue unchanged).
// Storage is a row of DEPTH cells; slot 0 is the oldest entry. A push raises
// every live cell's maximum in parallel and loads the tail cell; a pop shifts
// every cell one slot toward the head in the same cycle.
// The result is registered and valid in the cycle after the request is taken.
// Throughput: one request per cycle while results are taken; the single result
// register is the only buffer, so request.ready follows result.ready while a
// result is held. Reset (synchronous, rst high) empties the queue and drops any
// held result; no request is taken while rst is high.
// Cell contents are not cleared and are never shown until written.
// A stalled receiver holds the result and blocks new requests.
`include "max_tracking_fifo_assert.svh"

module max_tracking_fifo #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  mtf_req_if.sink  request,
  mtf_res_if.source result
);

  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   req_fire;
  logic                   full;
  logic                   empty;
  logic                   do_push;
  logic                   do_pop;
  logic [1:0]             err_next;

  logic signed [DATA_WIDTH-1:0] cell_value     [DEPTH];
  logic signed [DATA_WIDTH-1:0] cell_max       [DEPTH];
  logic signed [DATA_WIDTH-1:0] cell_value_nxt [DEPTH];
  logic signed [DATA_WIDTH-1:0] cell_max_nxt   [DEPTH];

  // Handshake and operation decode
  assign request.ready = !rst && (!result.valid || result.ready);
  assign req_fire      = request.valid && request.ready;
  assign full          = (count == COUNT_WIDTH'(DEPTH));
  assign empty         = (count == '0);
  assign do_push       = req_fire && (request.kind == mtf_pkg::KIND_PUSH) && !full;
  assign do_pop        = req_fire && (request.kind == mtf_pkg::KIND_POP) && !empty;

  // Count and error for the result
  always_comb begin
    count_next = count;
    err_next   = mtf_pkg::ERR_OK;
    if (do_push) begin
      count_next = count + COUNT_WIDTH'(1);
    end else if (do_pop) begin
      count_next = count - COUNT_WIDTH'(1);
    end
    if (request.kind == mtf_pkg::KIND_PUSH && full) begin
      err_next = mtf_pkg::ERR_PUSH_FULL;
    end else if (request.kind == mtf_pkg::KIND_POP && empty) begin
      err_next = mtf_pkg::ERR_POP_EMPTY;
    end
  end

  // Row of cells, each but the last fed by its younger neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mtf_pkg::cell_ctrl_t          ctrl;
    logic signed [DATA_WIDTH-1:0] sh_value;
    logic signed [DATA_WIDTH-1:0] sh_max;

    assign ctrl.push_en  = do_push;
    assign ctrl.pop_en   = do_pop;
    assign ctrl.occupied = (count > COUNT_WIDTH'(i));
    assign ctrl.is_tail  = (count == COUNT_WIDTH'(i));

    if (i == DEPTH - 1) begin : g_last
      assign sh_value = cell_value[i];
      assign sh_max   = cell_max[i];
    end else begin : g_mid
      assign sh_value = cell_value[i+1];
      assign sh_max   = cell_max[i+1];
    end

    mtf_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .push_value    (request.data_value),
      .shift_value   (sh_value),
      .shift_maximum (sh_max),
      .value         (cell_value[i]),
      .maximum       (cell_max[i]),
      .value_next    (cell_value_nxt[i]),
      .maximum_next  (cell_max_nxt[i])
    );
  end

  // Fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_fire) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Result payload, taken from the head cell's next state
  always_ff @(posedge clk) begin
    if (req_fire) begin
      result.entry_count <= count_next;
      result.is_empty    <= (count_next == '0);
      result.error_code  <= err_next;
      if (count_next == '0) begin
        result.front_value   <= '0;
        result.queue_maximum <= '0;
      end else begin
        result.front_value   <= cell_value_nxt[0];
        result.queue_maximum <= cell_max_nxt[0];
      end
    end
  end

  // Checks
  `MTF_ASSERT_IMPLIES(a_count_bound, 1'b1, count <= COUNT_WIDTH'(DEPTH))
  `MTF_ASSERT_NEXT(a_push_full, req_fire && request.kind == mtf_pkg::KIND_PUSH && full,
                   result.error_code == mtf_pkg::ERR_PUSH_FULL && $stable(count))
  `MTF_ASSERT_NEXT(a_pop_count, req_fire && request.kind == mtf_pkg::KIND_POP && !empty,
                   count == $past(count) - COUNT_WIDTH'(1))
  `MTF_ASSERT_IMPLIES(a_empty_flag, result.valid, result.is_empty == (result.entry_count == '0))
  `MTF_ASSERT_IMPLIES(a_max_front, result.valid && !result.is_empty,
                      result.queue_maximum >= result.front_value)

endmodule
